// ===== src/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the source text lexer
// Token kinds, lexer modes, token record and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package stl_pkg;

	localparam int OffsetBits = 32;
	localparam int LineBits = 24;
	localparam int ColumnBits = 16;
	localparam int MaxFracDigits = 9;
	localparam int FracBits = 30;
	localparam int FracCntBits = 4;
	localparam int KindBits = 5;
	localparam int QueueDepth = 4;
	localparam int QueuePtrBits = 2;

	localparam logic [KindBits-1:0] K_EOS = 5'd0;
	localparam logic [KindBits-1:0] K_STRING = 5'd14;
	localparam logic [KindBits-1:0] K_COMMENT = 5'd15;
	localparam logic [KindBits-1:0] K_SLASH = 5'd16;
	localparam logic [KindBits-1:0] K_EOL = 5'd17;
	localparam logic [KindBits-1:0] K_SPACING = 5'd18;
	localparam logic [KindBits-1:0] K_IDENT = 5'd19;
	localparam logic [KindBits-1:0] K_NUMBER = 5'd20;
	localparam logic [KindBits-1:0] K_UNKNOWN = 5'd21;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_DQ = 8'h22;
	localparam logic [7:0] CH_SQ = 8'h27;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_F = 8'h66;

	typedef enum logic [12:0] {
		M_IDLE     = 13'b0000000000001,
		M_DQ       = 13'b0000000000010,
		M_SQ       = 13'b0000000000100,
		M_SLASH    = 13'b0000000001000,
		M_LINE_CMT = 13'b0000000010000,
		M_BLOCK    = 13'b0000000100000,
		M_BLOCK_CR = 13'b0000001000000,
		M_BLOCK_LF = 13'b0000010000000,
		M_EOL_CR   = 13'b0000100000000,
		M_EOL_LF   = 13'b0001000000000,
		M_SPACE    = 13'b0010000000000,
		M_IDENT    = 13'b0100000000000,
		M_NUM      = 13'b1000000000000
	} mode_t;

	// classification of one byte, made in the front part
	typedef struct packed {
		logic [7:0] ch;
		logic is_nul;
		logic is_eol;
		logic is_space;
		logic is_alpha;
		logic is_digit;
		logic [KindBits-1:0] punct;
	} cls_t;

	typedef struct packed {
		logic [KindBits-1:0] kind;
		logic [OffsetBits-1:0] start;
		logic [OffsetBits-1:0] len;
		logic [LineBits-1:0] line;
		logic [ColumnBits-1:0] col;
		logic [31:0] ipart;
		logic [FracBits-1:0] fval;
		logic [FracCntBits-1:0] fcnt;
		logic last;
	} tok_t;

	function automatic logic [KindBits-1:0] punct_kind(input logic [7:0] b);
		logic [KindBits-1:0] k;
		unique case (b)
			8'h7b: k = 5'd1;
			8'h7d: k = 5'd2;
			8'h28: k = 5'd3;
			8'h29: k = 5'd4;
			8'h5b: k = 5'd5;
			8'h5d: k = 5'd6;
			8'h2c: k = 5'd7;
			8'h3a: k = 5'd8;
			8'h3b: k = 5'd9;
			8'h2e: k = 5'd10;
			8'h2b: k = 5'd11;
			8'h2d: k = 5'd12;
			8'h2a: k = 5'd13;
			default: k = K_EOS;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== src/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front: input stage and byte classifier
// Registers accepted bytes with their character classes into a small queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stl_front import stl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [7:0] char_byte,
	output logic cls_valid,
	output cls_t cls_data,
	input  wire logic cls_take
);

	cls_t mem_q [QueueDepth];
	logic [QueuePtrBits-1:0] wr_q, rd_q;
	logic [QueuePtrBits:0] cnt_q;
	cls_t c;
	logic do_push, do_pop;

	// classify
	always_comb begin
		c.ch = char_byte;
		c.is_nul = (char_byte == CH_NUL);
		c.is_eol = (char_byte == CH_CR) || (char_byte == CH_LF);
		c.is_space = (char_byte == 8'h20) || (char_byte == 8'h09) ||
			(char_byte == 8'h0b) || (char_byte == 8'h0c);
		c.is_alpha = (char_byte >= 8'h61 && char_byte <= 8'h7a) ||
			(char_byte >= 8'h41 && char_byte <= 8'h5a);
		c.is_digit = (char_byte >= 8'h30 && char_byte <= 8'h39);
		c.punct = punct_kind(char_byte);
	end

	assign full = (cnt_q == QueuePtrBits'(0) + (QueuePtrBits+1)'(QueueDepth));
	assign do_push = push && !full;
	assign cls_valid = (cnt_q != '0);
	assign do_pop = cls_take && cls_valid;
	assign cls_data = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= c;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrBits+1)'(do_push) - (QueuePtrBits+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ===== src/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back: lexer state machine
// Consumes one classified byte per cycle while its result queue has at least
// two free slots, and writes up to two tokens into the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stl_back import stl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cls_valid,
	input  cls_t cls_data,
	output logic cls_take,
	output logic empty,
	input  wire logic pop,
	output tok_t tok_out
);

	localparam logic [LineBits-1:0] LineTop = '1;
	localparam logic [ColumnBits-1:0] ColTop = '1;

	mode_t mode_q, md;
	logic esc_q, star_q, dot_q;
	logic [OffsetBits-1:0] off_q, pst_q;
	logic [LineBits-1:0] line_q, pln_q;
	logic [ColumnBits-1:0] col_q, pcl_q;
	logic [31:0] iacc_q;
	logic [FracBits-1:0] facc_q;
	logic [FracCntBits-1:0] fcnt_q;

	// next-state variables
	logic esc_d, star_d, dot_d;
	logic [OffsetBits-1:0] off_d, pst_d;
	logic [LineBits-1:0] line_d, pln_d;
	logic [ColumnBits-1:0] col_d, pcl_d;
	logic [31:0] iacc_d;
	logic [FracBits-1:0] facc_d;
	logic [FracCntBits-1:0] fcnt_d;

	tok_t t0, t1;
	logic v0, v1;
	logic again;
	logic [KindBits-1:0] pk;
	logic [35:0] imul;
	logic [3:0] dig;
	cls_t b;

	tok_t q_q [QueueDepth];
	logic [QueuePtrBits-1:0] wr_q, rd_q;
	logic [QueuePtrBits:0] cnt_q;
	logic room, fire;

	assign b = cls_data;
	assign dig = b.ch[3:0];
	assign room = (cnt_q <= (QueuePtrBits+1)'(QueueDepth - 2));
	assign cls_take = room;
	assign fire = cls_valid && room;

	function automatic logic [KindBits-1:0] kind_of(input mode_t m);
		logic [KindBits-1:0] k;
		unique case (m)
			M_DQ, M_SQ: k = K_STRING;
			M_SLASH: k = K_SLASH;
			M_LINE_CMT, M_BLOCK, M_BLOCK_CR, M_BLOCK_LF: k = K_COMMENT;
			M_EOL_CR, M_EOL_LF: k = K_EOL;
			M_SPACE: k = K_SPACING;
			M_IDENT: k = K_IDENT;
			default: k = K_NUMBER;
		endcase
		return k;
	endfunction

	// integer accumulate: times ten plus digit, saturating
	assign imul = {4'd0, iacc_q} * 36'd10 + {32'd0, dig};

	always_comb begin
		md = mode_q;
		esc_d = esc_q; star_d = star_q; dot_d = dot_q;
		off_d = off_q; pst_d = pst_q;
		line_d = line_q; pln_d = pln_q;
		col_d = col_q; pcl_d = pcl_q;
		iacc_d = iacc_q; facc_d = facc_q; fcnt_d = fcnt_q;
		v0 = 1'b0; v1 = 1'b0; again = 1'b0;
		t0 = '0; t1 = '0;
		pk = kind_of(mode_q);

		// on NUL, flush the pending token closing at off_q, then emit end of stream
		if (b.is_nul) begin
			if (mode_q != M_IDLE) begin
				v0 = 1'b1;
				t0.kind = pk; t0.start = pst_q; t0.len = off_q - pst_q;
				t0.line = pln_q; t0.col = pcl_q;
				if (pk == K_NUMBER) begin
					t0.ipart = iacc_q; t0.fval = facc_q; t0.fcnt = fcnt_q;
				end
			end
			t1.kind = K_EOS; t1.start = off_q; t1.line = line_q; t1.col = col_q;
			v1 = 1'b1;
			md = M_IDLE; esc_d = 1'b0; star_d = 1'b0; dot_d = 1'b0;
			off_d = '0; line_d = '0; col_d = '0; pst_d = '0; pln_d = '0; pcl_d = '0;
			iacc_d = '0; facc_d = '0; fcnt_d = '0;
		end else begin
			unique case (mode_q)
				M_DQ, M_SQ: begin
					if (esc_q) esc_d = 1'b0;
					else if (b.ch == ((mode_q == M_DQ) ? CH_DQ : CH_SQ)) begin
						v0 = 1'b1; md = M_IDLE;
					end else if (b.ch == CH_BSL) esc_d = 1'b1;
					off_d = off_q + 1'b1;
					if (col_q != ColTop) col_d = col_q + 1'b1;
				end
				M_SLASH: begin
					if (b.ch == CH_SLASH) md = M_LINE_CMT;
					else if (b.ch == CH_STAR) begin
						md = M_BLOCK; star_d = 1'b0;
					end else again = 1'b1;
					if (!again) begin
						off_d = off_q + 1'b1;
						if (col_q != ColTop) col_d = col_q + 1'b1;
					end
				end
				M_LINE_CMT: begin
					if (b.is_eol) again = 1'b1;
					else begin
						off_d = off_q + 1'b1;
						if (col_q != ColTop) col_d = col_q + 1'b1;
					end
				end
				M_BLOCK, M_BLOCK_CR, M_BLOCK_LF: begin
					off_d = off_q + 1'b1;
					if (col_q != ColTop) col_d = col_q + 1'b1;
					if (star_q && b.ch == CH_SLASH) begin
						v0 = 1'b1; md = M_IDLE; star_d = 1'b0;
					end else begin
						if ((mode_q == M_BLOCK_CR && b.ch == CH_LF) ||
							(mode_q == M_BLOCK_LF && b.ch == CH_CR)) md = M_BLOCK;
						else if (b.is_eol) begin
							if (line_q != LineTop) line_d = line_q + 1'b1;
							md = (b.ch == CH_CR) ? M_BLOCK_CR : M_BLOCK_LF;
						end else md = M_BLOCK;
						star_d = (b.ch == CH_STAR);
					end
				end
				M_EOL_CR, M_EOL_LF: begin
					if ((mode_q == M_EOL_CR && b.ch == CH_LF) ||
						(mode_q == M_EOL_LF && b.ch == CH_CR)) begin
						off_d = off_q + 1'b1; v0 = 1'b1; md = M_IDLE;
					end else again = 1'b1;
				end
				M_SPACE: begin
					if (b.is_space) begin
						off_d = off_q + 1'b1;
						if (col_q != ColTop) col_d = col_q + 1'b1;
					end else again = 1'b1;
				end
				M_IDENT: begin
					if (b.is_alpha || b.is_digit || b.ch == CH_UNDER) begin
						off_d = off_q + 1'b1;
						if (col_q != ColTop) col_d = col_q + 1'b1;
					end else again = 1'b1;
				end
				M_NUM: begin
					if (b.is_digit) begin
						if (!dot_q) iacc_d = (imul[35:32] != 4'd0) ? '1 : imul[31:0];
						else if (fcnt_q < FracCntBits'(MaxFracDigits)) begin
							facc_d = FracBits'(facc_q * FracBits'(10)) + FracBits'(dig);
							fcnt_d = fcnt_q + 1'b1;
						end
						off_d = off_q + 1'b1;
						if (col_q != ColTop) col_d = col_q + 1'b1;
					end else if (b.ch == CH_DOT && !dot_q) begin
						dot_d = 1'b1;
						off_d = off_q + 1'b1;
						if (col_q != ColTop) col_d = col_q + 1'b1;
					end else if (b.ch == CH_F) begin
						off_d = off_q + 1'b1;
						if (col_q != ColTop) col_d = col_q + 1'b1;
						v0 = 1'b1; md = M_IDLE;
					end else again = 1'b1;
				end
				default: ;
			endcase

			// flushed pending token (normal close or close before restart);
			// a string span stops before its closing quote
			if (v0 || again) begin
				v0 = 1'b1;
				t0.kind = pk; t0.start = pst_q;
				t0.len = ((mode_q == M_DQ || mode_q == M_SQ) ? off_q : off_d) - pst_q;
				t0.line = pln_q; t0.col = pcl_q;
				if (pk == K_NUMBER) begin
					t0.ipart = iacc_d; t0.fval = facc_d; t0.fcnt = fcnt_d;
				end
			end

			// start a new token from this byte
			if (again || mode_q == M_IDLE) begin
				md = M_IDLE;
				pst_d = off_q; pln_d = line_q; pcl_d = col_q;
				off_d = off_q + 1'b1;
				if (col_q != ColTop) col_d = col_q + 1'b1;
				if (b.punct != K_EOS || !(b.ch == CH_DQ || b.ch == CH_SQ ||
					b.ch == CH_SLASH || b.is_eol || b.is_space || b.is_alpha ||
					b.is_digit)) begin
					v1 = 1'b1;
					t1.kind = (b.punct != K_EOS) ? b.punct : K_UNKNOWN;
					t1.start = off_q; t1.len = OffsetBits'(1);
					t1.line = line_q; t1.col = col_q;
				end else if (b.ch == CH_DQ || b.ch == CH_SQ) begin
					md = (b.ch == CH_DQ) ? M_DQ : M_SQ;
					esc_d = 1'b0; pst_d = off_q + 1'b1;
				end else if (b.ch == CH_SLASH) md = M_SLASH;
				else if (b.is_eol) begin
					md = (b.ch == CH_CR) ? M_EOL_CR : M_EOL_LF;
					if (line_q != LineTop) line_d = line_q + 1'b1;
					col_d = '0;
				end else if (b.is_space) md = M_SPACE;
				else if (b.is_alpha) md = M_IDENT;
				else begin
					md = M_NUM; iacc_d = {28'd0, dig};
					facc_d = '0; fcnt_d = '0; dot_d = 1'b0;
				end
			end
		end
		if (v1) t1.last = 1'b1;
		else t0.last = 1'b1;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			esc_q <= 1'b0; star_q <= 1'b0; dot_q <= 1'b0;
			off_q <= '0; pst_q <= '0; line_q <= '0; pln_q <= '0;
			col_q <= '0; pcl_q <= '0; iacc_q <= '0; facc_q <= '0; fcnt_q <= '0;
		end else if (fire) begin
			mode_q <= md;
			esc_q <= esc_d; star_q <= star_d; dot_q <= dot_d;
			off_q <= off_d; pst_q <= pst_d; line_q <= line_d; pln_q <= pln_d;
			col_q <= col_d; pcl_q <= pcl_d; iacc_q <= iacc_d; facc_q <= facc_d;
			fcnt_q <= fcnt_d;
		end
	end

	// result queue: up to two tokens written per beat
	logic push0, push1, deq;
	logic [QueuePtrBits-1:0] wr1;
	assign push0 = fire && (v0 || v1);
	assign push1 = fire && v0 && v1;
	assign wr1 = wr_q + 1'b1;
	assign empty = (cnt_q == '0);
	assign deq = pop && !empty;
	assign tok_out = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push0) q_q[wr_q] <= v0 ? t0 : t1;
		if (push1) q_q[wr1] <= t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QueuePtrBits'(push0) + QueuePtrBits'(push1);
			if (deq) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrBits+1)'(push0) + (QueuePtrBits+1)'(push1)
				- (QueuePtrBits+1)'(deq);
		end
	end

endmodule
`default_nettype wire

// ===== src/source_text_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// source_text_lexer_unit: streaming source tokenizer
//   channel  | direction | handshake    | payload
//   bytes    | in        | push / full  | char_byte
//   tokens   | out       | pop / empty  | token_kind .. last_of_run
// One byte is taken per cycle while full is low; each byte gives zero to two tokens.
// The edge that takes a byte writes it to the front queue; the lexer state
// update then consumes it from there when the back has room and writes its
// tokens to the result queue, whose head drives the result ports.
// The back stalls when its four-entry token queue has under two free slots;
// sustained rate drops below one byte per cycle only when tokens are not popped.
// Asynchronous reset returns to offset, line and column zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module source_text_lexer_unit import stl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [7:0] char_byte,
	output logic empty,
	input  wire logic pop,
	output logic [4:0] token_kind,
	output logic [31:0] span_start,
	output logic [31:0] span_length,
	output logic [23:0] token_line,
	output logic [15:0] token_column,
	output logic [31:0] integer_part,
	output logic [29:0] fraction_digits_value,
	output logic [3:0] fraction_digit_count,
	output logic last_of_run
);

	logic cls_valid, cls_take;
	cls_t cls_data;
	tok_t tok;

	stl_front u_front (
		.clk, .arst_n, .push, .full, .char_byte,
		.cls_valid, .cls_data, .cls_take
	);

	stl_back u_back (
		.clk, .arst_n, .cls_valid, .cls_data, .cls_take,
		.empty, .pop, .tok_out(tok)
	);

	assign token_kind = tok.kind;
	assign span_start = tok.start;
	assign span_length = tok.len;
	assign token_line = tok.line;
	assign token_column = tok.col;
	assign integer_part = tok.ipart;
	assign fraction_digits_value = tok.fval;
	assign fraction_digit_count = tok.fcnt;
	assign last_of_run = tok.last;

endmodule
`default_nettype wire

// ===== src/stl_checker.sv =====
// ----------------------------------------------------------------------------
// stl_checker: port-level checks of the lexer
// Watches the result channel and attaches to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stl_checker import stl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire logic [4:0] token_kind,
	input wire logic [31:0] span_length,
	input wire logic [31:0] integer_part,
	input wire logic [3:0] fraction_digit_count,
	input wire logic last_of_run
);

	// a waiting beat holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(token_kind))
		else $error("result changed while stalled");

	// end of stream always closes a run with an empty span
	a_eos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token_kind == K_EOS |-> last_of_run && span_length == 32'd0)
		else $error("bad eos token");

	// numeric fields only on numbers
	a_num: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token_kind != K_NUMBER |-> integer_part == 32'd0 &&
		fraction_digit_count == 4'd0)
		else $error("numeric field on non-number");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> token_kind <= K_UNKNOWN &&
		fraction_digit_count <= FracCntBits'(MaxFracDigits))
		else $error("kind or count out of range");

endmodule

bind source_text_lexer_unit stl_checker u_stl_checker (
	.clk, .arst_n, .empty, .pop, .token_kind, .span_length,
	.integer_part, .fraction_digit_count, .last_of_run
);
`default_nettype wire
